// ===== hdl/miller_rabin_prime_test_assert.svh =====
// assertion macros for the prime test block
`ifndef MILLER_RABIN_PRIME_TEST_ASSERT_SVH
`define MILLER_RABIN_PRIME_TEST_ASSERT_SVH
`ifndef SYNTHESIS
`define MRP_ASSERT_IMPL(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error("mrp check failed");
`define MRP_ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error("mrp check failed");
`else
`define MRP_ASSERT_IMPL(label, clk, rst, a, c)
`define MRP_ASSERT_NEXT(label, clk, rst, a, c)
`endif
`endif

// ===== hdl/mrp_pkg.sv =====
`default_nettype none
package mrp_pkg;
  localparam int NumWidth = 32;
  localparam int InWidth = 32;
  localparam int WitnessCount = 8;
  localparam int WitnessIdxWidth = 3;

  function automatic logic [4:0] witness(input logic [WitnessIdxWidth-1:0] idx);
    logic [4:0] w;
    unique case (idx)
      3'd0: w = 5'd2;
      3'd1: w = 5'd3;
      3'd2: w = 5'd5;
      3'd3: w = 5'd7;
      3'd4: w = 5'd11;
      3'd5: w = 5'd13;
      3'd6: w = 5'd17;
      default: w = 5'd19;
    endcase
    return w;
  endfunction

  typedef enum logic [3:0] {
    ST_IDLE, ST_XX_WAIT, ST_SPLIT, ST_WSTART, ST_EXP_BIT, ST_MUL_WAIT, ST_SQ_CHECK,
    ST_SQ_WAIT, ST_DONE
  } state_t;

  typedef enum logic [3:0] {
    CMD_NONE, CMD_LOAD, CMD_SHIFT_Q, CMD_WINIT, CMD_MUL_RB, CMD_MUL_BB, CMD_MUL_XX,
    CMD_NEXT_BIT, CMD_WB_R, CMD_WB_BASE, CMD_WB_X, CMD_SET_X
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t op;
    logic    start_mul;
  } cmd_t;

  typedef struct packed {
    logic q_even;
    logic trivial;
    logic trivial_prime;
    logic witness_ok;
    logic e_zero;
    logic e_lsb;
    logic mul_busy;
    logic x_one;
    logic x_nm1;
    logic k_zero;
  } status_t;
endpackage
`default_nettype wire

// ===== hdl/mrp_mulmod.sv =====
`default_nettype none
module mrp_mulmod #(
  parameter int NUM_WIDTH = mrp_pkg::NumWidth
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  input  wire logic [NUM_WIDTH-1:0] a,
  input  wire logic [NUM_WIDTH-1:0] b,
  input  wire logic [NUM_WIDTH-1:0] m,
  output logic                      busy,
  output logic [NUM_WIDTH-1:0]      result
);
  logic [NUM_WIDTH-1:0] sa, sb, acc;
  logic [NUM_WIDTH:0] sum_acc, dbl;
  logic [NUM_WIDTH-1:0] acc_next, sa_next;

  always_comb begin
    sum_acc = {1'b0, acc} + {1'b0, sa};
    acc_next = (sum_acc >= {1'b0, m}) ? NUM_WIDTH'(sum_acc - {1'b0, m})
                                      : sum_acc[NUM_WIDTH-1:0];
    if (!sb[0]) acc_next = acc;
    dbl = {sa, 1'b0};
    sa_next = (dbl >= {1'b0, m}) ? NUM_WIDTH'(dbl - {1'b0, m}) : dbl[NUM_WIDTH-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      sa <= a;
      sb <= b;
      acc <= '0;
    end else if (busy) begin
      if (sb == '0) begin
        busy <= 1'b0;
      end else begin
        acc <= acc_next;
        sa <= sa_next;
        sb <= sb >> 1;
      end
    end
  end

  assign result = acc;
endmodule
`default_nettype wire

// ===== hdl/mrp_datapath.sv =====
`default_nettype none
`include "miller_rabin_prime_test_assert.svh"
module mrp_datapath #(
  parameter int NUM_WIDTH = mrp_pkg::NumWidth
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic [mrp_pkg::InWidth-1:0] candidate_value,
  input  wire mrp_pkg::cmd_t              cmd,
  output mrp_pkg::status_t                status
);
  localparam int KW = $clog2(NUM_WIDTH + 1);
  logic [NUM_WIDTH-1:0] n, q, e, r, base, x, ma, mb;
  logic [KW-1:0] k, kc;
  logic [mrp_pkg::WitnessIdxWidth-1:0] widx;
  logic wdone;
  logic mbusy;
  logic [NUM_WIDTH-1:0] mres;
  logic [NUM_WIDTH-1:0] nin;
  logic [NUM_WIDTH-1:0] wval;

  always_comb begin
    nin = NUM_WIDTH'(candidate_value);
    wval = NUM_WIDTH'(mrp_pkg::witness(widx));
    ma = x;
    mb = x;
    unique case (cmd.op)
      mrp_pkg::CMD_MUL_RB: begin ma = r; mb = base; end
      mrp_pkg::CMD_MUL_BB: begin ma = base; mb = base; end
      default: begin ma = x; mb = x; end
    endcase
  end

  mrp_mulmod #(.NUM_WIDTH(NUM_WIDTH)) u_mul (
    .clk(clk), .rst(rst), .start(cmd.start_mul), .a(ma), .b(mb), .m(n),
    .busy(mbusy), .result(mres)
  );

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      mrp_pkg::CMD_LOAD: begin
        n <= nin;
        q <= nin - NUM_WIDTH'(1);
        k <= '0;
        widx <= '0;
        wdone <= 1'b0;
      end
      mrp_pkg::CMD_SHIFT_Q: begin
        q <= q >> 1;
        k <= k + KW'(1);
      end
      mrp_pkg::CMD_WINIT: begin
        e <= q;
        r <= NUM_WIDTH'(1);
        base <= wval;
        kc <= k;
      end
      mrp_pkg::CMD_WB_R: r <= mres;
      mrp_pkg::CMD_WB_BASE: begin
        base <= mres;
        e <= e >> 1;
      end
      mrp_pkg::CMD_WB_X: begin
        x <= mres;
        kc <= kc - KW'(1);
      end
      mrp_pkg::CMD_SET_X: x <= r;
      mrp_pkg::CMD_NEXT_BIT: begin
        if (widx == 3'(mrp_pkg::WitnessCount - 1)) wdone <= 1'b1;
        widx <= widx + 3'd1;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    status.q_even = ~q[0];
    status.trivial = ~nin[0] || (nin == NUM_WIDTH'(1));
    status.trivial_prime = (nin == NUM_WIDTH'(2));
    status.witness_ok = !wdone && (wval < n);
    status.e_zero = (e == '0);
    status.e_lsb = e[0];
    status.mul_busy = mbusy;
    status.x_one = (x == NUM_WIDTH'(1));
    status.x_nm1 = (x == n - NUM_WIDTH'(1));
    status.k_zero = (kc == '0);
  end

  `MRP_ASSERT_NEXT(a_start_busy, clk, rst, cmd.start_mul, mbusy)
  `MRP_ASSERT_IMPL(a_no_restart, clk, rst, cmd.start_mul, !mbusy)
  `MRP_ASSERT_NEXT(a_shift_k, clk, rst, cmd.op == mrp_pkg::CMD_SHIFT_Q, k != '0)
endmodule
`default_nettype wire

// ===== hdl/mrp_ctrl.sv =====
`default_nettype none
module mrp_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_stall,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic                  is_prime,
  input  wire mrp_pkg::status_t status,
  output mrp_pkg::cmd_t         cmd
);
  mrp_pkg::state_t state, state_next;
  logic res, res_next, ov, ov_next, sq_phase, sq_phase_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mrp_pkg::ST_IDLE;
      ov <= 1'b0;
      res <= 1'b0;
      sq_phase <= 1'b0;
    end else begin
      state <= state_next;
      ov <= ov_next;
      res <= res_next;
      sq_phase <= sq_phase_next;
    end
  end

  always_comb begin
    state_next = state;
    res_next = res;
    ov_next = ov && out_stall;
    sq_phase_next = sq_phase;
    cmd.op = mrp_pkg::CMD_NONE;
    cmd.start_mul = 1'b0;
    in_stall = 1'b1;
    unique case (state)
      mrp_pkg::ST_IDLE: begin
        in_stall = ov;
        if (in_valid && !ov) begin
          if (status.trivial) begin
            res_next = status.trivial_prime;
            ov_next = 1'b1;
          end else begin
            cmd.op = mrp_pkg::CMD_LOAD;
            state_next = mrp_pkg::ST_SPLIT;
          end
        end
      end
      mrp_pkg::ST_SPLIT: begin
        if (status.q_even) cmd.op = mrp_pkg::CMD_SHIFT_Q;
        else state_next = mrp_pkg::ST_WSTART;
      end
      mrp_pkg::ST_WSTART: begin
        if (!status.witness_ok) begin
          res_next = 1'b1;
          state_next = mrp_pkg::ST_DONE;
        end else begin
          cmd.op = mrp_pkg::CMD_WINIT;
          state_next = mrp_pkg::ST_EXP_BIT;
        end
      end
      mrp_pkg::ST_EXP_BIT: begin
        if (status.e_zero) begin
          cmd.op = mrp_pkg::CMD_SET_X;
          sq_phase_next = 1'b0;
          state_next = mrp_pkg::ST_SQ_CHECK;
        end else if (status.e_lsb) begin
          cmd.op = mrp_pkg::CMD_MUL_RB;
          cmd.start_mul = 1'b1;
          state_next = mrp_pkg::ST_MUL_WAIT;
        end else begin
          cmd.op = mrp_pkg::CMD_MUL_BB;
          cmd.start_mul = 1'b1;
          sq_phase_next = 1'b0;
          state_next = mrp_pkg::ST_SQ_WAIT;
        end
      end
      mrp_pkg::ST_MUL_WAIT: begin
        if (!status.mul_busy) begin
          cmd.op = mrp_pkg::CMD_WB_R;
          sq_phase_next = 1'b1;
          state_next = mrp_pkg::ST_SQ_WAIT;
        end
      end
      mrp_pkg::ST_SQ_WAIT: begin
        if (sq_phase) begin
          cmd.op = mrp_pkg::CMD_MUL_BB;
          cmd.start_mul = 1'b1;
          sq_phase_next = 1'b0;
        end else if (!status.mul_busy) begin
          cmd.op = mrp_pkg::CMD_WB_BASE;
          state_next = mrp_pkg::ST_EXP_BIT;
        end
      end
      mrp_pkg::ST_SQ_CHECK: begin
        if (!sq_phase && status.x_one) begin
          cmd.op = mrp_pkg::CMD_NEXT_BIT;
          state_next = mrp_pkg::ST_WSTART;
        end else if (!sq_phase) begin
          sq_phase_next = 1'b1;
        end else if (status.k_zero) begin
          res_next = 1'b0;
          sq_phase_next = 1'b0;
          state_next = mrp_pkg::ST_DONE;
        end else if (status.x_nm1) begin
          cmd.op = mrp_pkg::CMD_NEXT_BIT;
          sq_phase_next = 1'b0;
          state_next = mrp_pkg::ST_WSTART;
        end else begin
          cmd.op = mrp_pkg::CMD_MUL_XX;
          cmd.start_mul = 1'b1;
          state_next = mrp_pkg::ST_XX_WAIT;
        end
      end
      mrp_pkg::ST_XX_WAIT: begin
        if (!status.mul_busy) begin
          cmd.op = mrp_pkg::CMD_WB_X;
          state_next = mrp_pkg::ST_SQ_CHECK;
        end
      end
      mrp_pkg::ST_DONE: begin
        ov_next = 1'b1;
        state_next = mrp_pkg::ST_IDLE;
      end
      default: state_next = mrp_pkg::ST_IDLE;
    endcase
  end

  assign out_valid = ov;
  assign is_prime = res;
endmodule
`default_nettype wire

// ===== hdl/miller_rabin_prime_test.sv =====
// 0, 1 and even numbers are answered from the idle state; other numbers run up to 8 witness tests
// one number at a time: no new number is taken while one is under test; the modular multiplier is bit-serial
// the next beat is taken the cycle after the result beat leaves
// reset: synchronous active-high rst clears the controller and the output flag
`default_nettype none
module miller_rabin_prime_test #(
  parameter int NUM_WIDTH = mrp_pkg::NumWidth
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [mrp_pkg::InWidth-1:0] candidate_value,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic                             is_prime
);
  mrp_pkg::cmd_t cmd;
  mrp_pkg::status_t status;

  mrp_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .is_prime(is_prime),
    .status(status), .cmd(cmd)
  );

  mrp_datapath #(.NUM_WIDTH(NUM_WIDTH)) u_dp (
    .clk(clk), .rst(rst), .candidate_value(candidate_value), .cmd(cmd), .status(status)
  );
endmodule
`default_nettype wire

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [31:0] candidate_value;
  logic        out_valid;
  logic        out_stall;
  logic        is_prime;

  logic [31:0] pending_numbers[$];
  logic        expected_flags[$];
  int          error_count = 0;
  int          rcv_count = 0;
  int          burst_left;
  int          gap_left;
  int          long_hold;
  int          stall_phase;
  bit          long_hold_req;

  miller_rabin_prime_test u_dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .candidate_value(candidate_value), .out_valid(out_valid),
    .out_stall(out_stall), .is_prime(is_prime)
  );

  function automatic logic [63:0] mulmod(logic [63:0] a, logic [63:0] b, logic [63:0] m);
    logic [127:0] p;
    p = 128'(a) * 128'(b);
    return 64'(p % 128'(m));
  endfunction

  function automatic logic [63:0] powmod(logic [63:0] b, logic [63:0] e, logic [63:0] m);
    logic [63:0] r;
    r = 64'(1) % m;
    b = b % m;
    while (e != 0) begin
      if (e[0]) r = mulmod(r, b, m);
      b = mulmod(b, b, m);
      e = e >> 1;
    end
    return r;
  endfunction

  function automatic logic primality(logic [31:0] v);
    logic [63:0] n, q, x;
    int k;
    int wl[8];
    bit ok;
    wl = '{2, 3, 5, 7, 11, 13, 17, 19};
    n = 64'(v);
    if (!n[0] || n == 1) return n == 2;
    q = n - 1;
    k = 0;
    while (!q[0]) begin
      q = q >> 1;
      k++;
    end
    for (int j = 0; j < 8; j++) begin
      if (64'(wl[j]) >= n) break;
      x = powmod(64'(wl[j]), q, n);
      ok = (x == 1);
      for (int i = 0; i < k && !ok; i++) begin
        if (x == n - 1) ok = 1;
        else x = mulmod(x, x, n);
      end
      if (!ok) return 0;
    end
    return 1;
  endfunction

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 0;
      candidate_value <= '0;
      burst_left <= 0;
      gap_left <= 0;
    end else if (!(in_valid && in_stall)) begin
      if (in_valid && !in_stall) begin
        expected_flags.push_back(primality(candidate_value));
      end
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 0;
      end else if (pending_numbers.size() > 0) begin
        candidate_value <= pending_numbers.pop_front();
        in_valid <= 1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(8, 1);
          gap_left <= ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(6, 0);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 0;
      end
    end
  end

  // receiver stall pattern
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 0;
      long_hold <= 0;
      stall_phase <= 0;
    end else if (long_hold > 0) begin
      long_hold <= long_hold - 1;
      out_stall <= (long_hold > 1);
    end else if (long_hold_req) begin
      long_hold <= 3000;
      out_stall <= 1;
    end else begin
      stall_phase <= stall_phase + 1;
      if (stall_phase[9]) out_stall <= 0;
      else out_stall <= ($urandom_range(3, 0) == 0);
    end
  end

  // monitor
  always @(posedge clk) begin
    logic exp_flag;
    if (!rst && out_valid && !out_stall) begin
      rcv_count++;
      if (expected_flags.size() == 0) begin
        $display("%0t: unexpected beat, actual is_prime=%0b", $time, is_prime);
        error_count++;
      end else begin
        exp_flag = expected_flags.pop_front();
        if (exp_flag !== is_prime) begin
          $display("%0t: is_prime mismatch, expected %0b actual %0b", $time, exp_flag,
                   is_prime);
          error_count++;
        end
      end
    end
  end

  initial begin
    logic [31:0] v;
    int n_total;
    long_hold_req = 0;
    rst = 1;
    pending_numbers = '{0, 1, 2, 3, 4, 5, 9, 15, 17, 19, 21, 23, 25, 561, 1105,
                        2047, 32'd3215031751, 32'hFFFFFFFF, 32'hFFFFFFFB, 32'hFFFFFFFE,
                        32'h80000000, 32'h80000001, 2147483647, 32'd4294967291, 341};
    n_total = pending_numbers.size();
    repeat (4) @(posedge clk);
    rst <= 0;
    // sender pauses until every result so far has come back
    wait (rcv_count >= n_total);
    repeat (5) @(posedge clk);
    for (int i = 0; i < 100; i++) begin
      case ($urandom_range(3, 0))
        0: v = $urandom_range(1000, 0);
        1: v = $urandom | 32'h1;
        2: v = $urandom;
        default: begin
          v = $urandom | 32'h1;
          while (!primality(v)) v = v + 2;
        end
      endcase
      pending_numbers.push_back(v);
      n_total++;
      if (i == 20) begin
        @(posedge clk);
        long_hold_req <= 1;
        @(posedge clk);
        long_hold_req <= 0;
      end
    end
    wait (rcv_count >= n_total);
    repeat (50) @(posedge clk);
    if (error_count == 0 && expected_flags.size() == 0 && rcv_count == n_total) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #400ms;
    $display("*** FAILED ***");
    $finish;
  end
endmodule
`default_nettype wire
